[src/pbts_pkg.sv]
package pbts_pkg;

  localparam int MAX_TABLE_SIDE = 64;
  localparam int MIN_TABLE_SIDE = 2;
  localparam int SIDE_RESET     = 64;

  localparam int CFG_W       = 7;
  localparam int COORD_W     = 40;
  localparam int WR_INDEX_W  = 12;
  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  localparam int WRAP_W      = 24;

  localparam int STORE_DEPTH = MAX_TABLE_SIDE * MAX_TABLE_SIDE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_TABLE_SIDE);
  localparam int N_W         = $clog2(MAX_TABLE_SIDE + 1);
  localparam int HLERP_W     = SAMPLE_W + FRAC_W;

  localparam int CREDITS     = 4;
  localparam int CNT_W       = $clog2(CREDITS + 1);
  localparam int PTR_W       = $clog2(CREDITS);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic [IDX_W-1:0]           idx_t;
  typedef logic [N_W-1:0]             side_t;
  typedef logic [FRAC_W-1:0]          frac_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [CFG_W-1:0]           cfg_side_t;

  typedef struct packed {
    logic    we;
    addr_t   waddr;
    sample_t wdata;
    addr_t   raddr0;
    addr_t   raddr1;
  } mem_req_t;

  typedef struct packed {
    logic  v;
    logic  last;
    frac_t fu;
    frac_t fw;
  } rd_tag_t;

  function automatic side_t side_clamp(cfg_side_t s);
    if (32'(s) < 32'(MIN_TABLE_SIDE)) begin
      return side_t'(MIN_TABLE_SIDE);
    end else if (32'(s) > 32'(MAX_TABLE_SIDE)) begin
      return side_t'(MAX_TABLE_SIDE);
    end
    return side_t'(s);
  endfunction

endpackage

[src/pbts_channels.sv]
interface pbts_in_if import pbts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic [WR_INDEX_W-1:0]     write_index;
  logic signed [SAMPLE_W-1:0] write_value;

  modport source (output valid, op, x_coord, z_coord, write_index, write_value,
                  input ready);
  modport sink (input valid, op, x_coord, z_coord, write_index, write_value,
                output ready);
endinterface

interface pbts_out_if import pbts_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, sample_value, input ready);
  modport sink (input valid, sample_value, output ready);
endinterface

interface pbts_cfg_if import pbts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] table_side;

  modport source (output valid, table_side, input ready);
  modport sink (input valid, table_side, output ready);
endinterface

[src/pbts_addr.sv]
module pbts_addr import pbts_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic                       in_op,
  input  logic signed [COORD_W-1:0]  in_x,
  input  logic signed [COORD_W-1:0]  in_z,
  input  logic [WR_INDEX_W-1:0]      in_windex,
  input  sample_t                    in_wvalue,
  input  side_t                      side_n,
  output logic                       s1_free,
  output mem_req_t                   mem_req,
  output rd_tag_t                    rd_tag
);

  localparam int PROD_W = WRAP_W + N_W;

  logic [PROD_W-1:0] tx, tz;
  idx_t              i0, i1, j0, j1;
  frac_t             fu, fw;
  logic [N_W-1:0]    i_inc, j_inc;
  logic              wen;

  logic    s1_v_r;
  op_t     s1_op_r;
  idx_t    s1_i0_r, s1_i1_r, s1_j0_r, s1_j1_r;
  frac_t   s1_fu_r, s1_fw_r;
  logic    s1_wen_r;
  addr_t   s1_waddr_r;
  sample_t s1_wdata_r;

  logic    s2_v_r;
  op_t     s2_op_r;
  addr_t   s2_rb0_r, s2_rb1_r;
  idx_t    s2_i0_r, s2_i1_r;
  frac_t   s2_fu_r, s2_fw_r;
  logic    s2_wen_r;
  addr_t   s2_waddr_r;
  sample_t s2_wdata_r;
  logic    phase_r;

  logic    s2_done, s2_free;
  addr_t   row;

  always_comb begin
    tx    = PROD_W'(in_x[WRAP_W-1:0]) * PROD_W'(side_n);
    tz    = PROD_W'(in_z[WRAP_W-1:0]) * PROD_W'(side_n);
    i0    = tx[WRAP_W +: IDX_W];
    j0    = tz[WRAP_W +: IDX_W];
    fu    = tx[WRAP_W-1 -: FRAC_W];
    fw    = tz[WRAP_W-1 -: FRAC_W];
    i_inc = N_W'(i0) + N_W'(1);
    j_inc = N_W'(j0) + N_W'(1);
    i1    = (i_inc == side_n) ? '0 : i_inc[IDX_W-1:0];
    j1    = (j_inc == side_n) ? '0 : j_inc[IDX_W-1:0];
    wen   = 32'(in_windex) < 32'(STORE_DEPTH);
  end

  assign s2_done = s2_v_r && (s2_op_r == OP_WRITE || phase_r);
  assign s2_free = !s2_v_r || s2_done;
  assign s1_free = !s1_v_r || s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_r <= in_take;
      end
      if (s2_free) begin
        s2_v_r  <= s1_v_r;
        phase_r <= 1'b0;
      end else if (s2_v_r) begin
        phase_r <= !phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= op_t'(in_op);
      s1_i0_r    <= i0;
      s1_i1_r    <= i1;
      s1_j0_r    <= j0;
      s1_j1_r    <= j1;
      s1_fu_r    <= fu;
      s1_fw_r    <= fw;
      s1_wen_r   <= wen;
      s1_waddr_r <= ADDR_W'(in_windex);
      s1_wdata_r <= in_wvalue;
    end
    if (s2_free && s1_v_r) begin
      s2_op_r    <= s1_op_r;
      s2_rb0_r   <= ADDR_W'(ADDR_W'(s1_j0_r) * ADDR_W'(side_n));
      s2_rb1_r   <= ADDR_W'(ADDR_W'(s1_j1_r) * ADDR_W'(side_n));
      s2_i0_r    <= s1_i0_r;
      s2_i1_r    <= s1_i1_r;
      s2_fu_r    <= s1_fu_r;
      s2_fw_r    <= s1_fw_r;
      s2_wen_r   <= s1_wen_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wdata_r <= s1_wdata_r;
    end
  end

  always_comb begin
    row            = phase_r ? s2_rb1_r : s2_rb0_r;
    mem_req.we     = s2_v_r && s2_op_r == OP_WRITE && s2_wen_r;
    mem_req.waddr  = s2_waddr_r;
    mem_req.wdata  = s2_wdata_r;
    mem_req.raddr0 = row + ADDR_W'(s2_i0_r);
    mem_req.raddr1 = row + ADDR_W'(s2_i1_r);
    rd_tag.v       = s2_v_r && s2_op_r == OP_SAMPLE;
    rd_tag.last    = phase_r;
    rd_tag.fu      = s2_fu_r;
    rd_tag.fw      = s2_fw_r;
  end

  a_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_op_r == OP_SAMPLE && !phase_r |=> s2_v_r && phase_r && $stable(s2_rb1_r))
    else $error("sample left read stage after one phase");

  a_wr_rd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> !rd_tag.v)
    else $error("table write and read in the same cycle");

endmodule

[src/pbts_table.sv]
module pbts_table import pbts_pkg::*; (
  input  logic     clk,
  input  mem_req_t mem_req,
  output sample_t  rdata0,
  output sample_t  rdata1
);

  sample_t mem [STORE_DEPTH];
  sample_t rdata0_r, rdata1_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata0_r <= mem[mem_req.raddr0];
    rdata1_r <= mem[mem_req.raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

[src/pbts_lerp.sv]
module pbts_lerp import pbts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  rd_tag_t rd_tag,
  input  sample_t rdata0,
  input  sample_t rdata1,
  output logic    res_v,
  output sample_t res_value
);

  localparam int HP_W    = HLERP_W + 2;
  localparam int TOTAL_W = HLERP_W + FRAC_W + 2;
  localparam logic signed [TOTAL_W-1:0] HALF = TOTAL_W'(1) <<< (2 * FRAC_W - 1);

  rd_tag_t                    tag_r;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [HP_W-1:0]     h_full;
  logic signed [HLERP_W-1:0]  h;
  logic signed [HLERP_W-1:0]  a_r;
  logic                       t_v_r;
  logic signed [HLERP_W-1:0]  t_a_r, t_b_r;
  frac_t                      t_fw_r;
  logic signed [HLERP_W:0]    dab;
  logic signed [TOTAL_W-1:0]  total;

  always_comb begin
    diff   = (SAMPLE_W+1)'(rdata1) - (SAMPLE_W+1)'(rdata0);
    h_full = (HP_W'(rdata0) <<< FRAC_W)
           + HP_W'(diff) * HP_W'($signed({1'b0, tag_r.fu}));
    h      = h_full[HLERP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
      t_v_r <= 1'b0;
    end else begin
      tag_r <= rd_tag;
      t_v_r <= tag_r.v && tag_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.v && !tag_r.last) begin
      a_r <= h;
    end
    if (tag_r.v && tag_r.last) begin
      t_a_r  <= a_r;
      t_b_r  <= h;
      t_fw_r <= tag_r.fw;
    end
  end

  always_comb begin
    dab   = (HLERP_W+1)'(t_b_r) - (HLERP_W+1)'(t_a_r);
    total = (TOTAL_W'(t_a_r) <<< FRAC_W)
          + TOTAL_W'(dab) * TOTAL_W'($signed({1'b0, t_fw_r}))
          + HALF;
  end

  assign res_v     = t_v_r;
  assign res_value = total[2*FRAC_W +: SAMPLE_W];

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r.v && !tag_r.last |=> tag_r.v && tag_r.last)
    else $error("second row pair missing after first");

endmodule

[src/periodic_bilinear_table_sampler_core.sv]
// Periodic bilinear table sampler. Write transactions (op 0) store one Q1.14
// word and are taken one per cycle while ready is high; sample transactions
// (op 1) hold the read stage while the four neighbor reads share the table's
// two read ports, one row pair after the other. Up to 4 results are buffered
// at the output; with 4 samples unclaimed the input holds ready low. The user
// writes table_side through cfg_ch only while the block is idle, which the
// block does not enforce; out-of-range values act as the nearest of 2 and 64.
module periodic_bilinear_table_sampler_core import pbts_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  pbts_in_if.sink   in_ch,
  pbts_out_if.source out_ch,
  pbts_cfg_if.sink  cfg_ch
);

  side_t      side_n_r;
  logic       s1_free;
  logic       in_take, sample_take, pop, push;
  logic [CNT_W-1:0] cnt_r, fill_r;
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  sample_t    fifo_mem [CREDITS];
  mem_req_t   mem_req;
  rd_tag_t    rd_tag;
  sample_t    rdata0, rdata1;
  sample_t    res_value;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_n_r <= side_clamp(cfg_side_t'(SIDE_RESET));
    end else if (cfg_ch.valid) begin
      side_n_r <= side_clamp(cfg_ch.table_side);
    end
  end

  assign in_ch.ready = s1_free && (cnt_r < CNT_W'(CREDITS));
  assign in_take     = in_ch.valid && in_ch.ready;
  assign sample_take = in_take && in_ch.op == OP_SAMPLE;
  assign pop         = out_ch.valid && out_ch.ready;

  pbts_addr u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_take   (in_take),
    .in_op     (in_ch.op),
    .in_x      (in_ch.x_coord),
    .in_z      (in_ch.z_coord),
    .in_windex (in_ch.write_index),
    .in_wvalue (in_ch.write_value),
    .side_n    (side_n_r),
    .s1_free   (s1_free),
    .mem_req   (mem_req),
    .rd_tag    (rd_tag)
  );

  pbts_table u_table (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata0  (rdata0),
    .rdata1  (rdata1)
  );

  pbts_lerp u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_tag    (rd_tag),
    .rdata0    (rdata0),
    .rdata1    (rdata1),
    .res_v     (push),
    .res_value (res_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      fill_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r  <= cnt_r + CNT_W'(sample_take) - CNT_W'(pop);
      fill_r <= fill_r + CNT_W'(push) - CNT_W'(pop);
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= res_value;
    end
  end

  assign out_ch.valid        = fill_r != '0;
  assign out_ch.sample_value = fifo_mem[rd_ptr_r];

  a_fill_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cnt_r && cnt_r <= CNT_W'(CREDITS))
    else $error("result count exceeds outstanding samples");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r != CNT_W'(CREDITS))
    else $error("result buffer overflow");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pbts_pkg::*;

  localparam int RUN_LIMIT       = 400000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int N_ITEMS         = 600;
  localparam int N_DIRECTED      = 21;
  localparam int N_PHASES        = 10;

  typedef logic signed [COORD_W-1:0] coord_t;

  // side 64: one cell is 4.0 in coordinate units
  localparam coord_t CELL      = 40'sh00_0004_0000;
  localparam coord_t HALF_CELL = 40'sh00_0002_0000;
  localparam coord_t PERIOD    = 40'sh00_0100_0000;
  localparam coord_t NEG_PER   = 40'shFF_FF00_0000;
  localparam coord_t LAST_CELL = 40'sh00_00FC_0000;
  localparam coord_t C_MAX     = 40'sh7F_FFFF_FFFF;
  localparam coord_t C_MIN     = 40'sh80_0000_0000;
  localparam coord_t C_ONES    = 40'shFF_FFFF_FFFF;

  typedef struct packed {
    addr_t [3:0] corner;
    frac_t       fu;
    frac_t       fw;
  } footprint_t;

  typedef struct packed {
    op_t     op;
    coord_t  x;
    coord_t  z;
    addr_t   idx;
    sample_t val;
    logic    fixed;
    sample_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  pbts_in_if  in_ch();
  pbts_out_if out_ch();
  pbts_cfg_if cfg_ch();

  periodic_bilinear_table_sampler_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  sample_t       table_words [STORE_DEPTH];
  bit            written_words [STORE_DEPTH];
  sample_t       expected_samples [$];
  cfg_side_t     cur_side = cfg_side_t'(SIDE_RESET);
  int            idle_pct = 0;
  int            mismatch_count = 0;
  int            sent_count = 0;
  int unsigned   cycle_count = 0;
  sample_t       oldest_sample;
  int            sink_stall = 0;
  directed_row_t directed_rows [N_DIRECTED];
  cfg_side_t     phase_sides [N_PHASES];

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic int eff_side(cfg_side_t s);
    if (int'(s) < MIN_TABLE_SIDE) return MIN_TABLE_SIDE;
    if (int'(s) > MAX_TABLE_SIDE) return MAX_TABLE_SIDE;
    return int'(s);
  endfunction

  function automatic footprint_t footprint(coord_t x, coord_t z);
    footprint_t  fp;
    int          n;
    logic [31:0] tx;
    logic [31:0] tz;
    int          i0, i1, j0, j1;
    n  = eff_side(cur_side);
    tx = 32'(x[WRAP_W-1:0]) * 32'(n);
    tz = 32'(z[WRAP_W-1:0]) * 32'(n);
    i0 = int'(tx[31:24]);
    j0 = int'(tz[31:24]);
    i1 = (i0 + 1 == n) ? 0 : i0 + 1;
    j1 = (j0 + 1 == n) ? 0 : j0 + 1;
    fp.fu = tx[23:8];
    fp.fw = tz[23:8];
    fp.corner[0] = addr_t'(j0 * n + i0);
    fp.corner[1] = addr_t'(j0 * n + i1);
    fp.corner[2] = addr_t'(j1 * n + i0);
    fp.corner[3] = addr_t'(j1 * n + i1);
    return fp;
  endfunction

  function automatic sample_t predict_sample(coord_t x, coord_t z);
    footprint_t fp;
    longint     v00, v10, v01, v11, wu, ww, top, bot, acc;
    fp  = footprint(x, z);
    v00 = longint'(table_words[fp.corner[0]]);
    v10 = longint'(table_words[fp.corner[1]]);
    v01 = longint'(table_words[fp.corner[2]]);
    v11 = longint'(table_words[fp.corner[3]]);
    wu  = longint'(fp.fu);
    ww  = longint'(fp.fw);
    top = v00 * (65536 - wu) + v10 * wu;
    bot = v01 * (65536 - wu) + v11 * wu;
    acc = top * (65536 - ww) + bot * ww + (longint'(1) <<< 31);
    return sample_t'(acc >>> 32);
  endfunction

  function automatic coord_t pick_coord();
    coord_t c;
    c = COORD_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: c[FRAC_W-1:0] = '0;
      1: c[FRAC_W-1:0] = '1;
      2: c[COORD_W-1:WRAP_W] = {(COORD_W-WRAP_W){c[COORD_W-1]}};
      3: c[WRAP_W-1:0] = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: ;
    endcase
    return c;
  endfunction

  function automatic sample_t pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic push_transaction(op_t op, coord_t x, coord_t z, addr_t idx, sample_t val);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.x_coord     <= x;
    in_ch.z_coord     <= z;
    in_ch.write_index <= idx;
    in_ch.write_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic run_write(addr_t idx, sample_t val);
    push_transaction(OP_WRITE, pick_coord(), pick_coord(), idx, val);
    table_words[idx]   = val;
    written_words[idx] = 1'b1;
  endtask

  // fill any unwritten neighbor first so no read hits an undefined entry
  task automatic run_sample(coord_t x, coord_t z, logic fixed, sample_t want);
    footprint_t fp;
    fp = footprint(x, z);
    for (int k = 0; k < 4; k++) begin
      if (!written_words[fp.corner[k]]) run_write(fp.corner[k], pick_value());
    end
    push_transaction(OP_SAMPLE, x, z, ADDR_W'($urandom()), SAMPLE_W'($urandom()));
    expected_samples.push_back(fixed ? want : predict_sample(x, z));
  endtask

  task automatic set_side(cfg_side_t s);
    in_ch.valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.table_side <= s;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_side = s;
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall > 0) begin
        out_ch.ready <= 1'b0;
        sink_stall--;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        sink_stall = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d",
                 $time, out_ch.sample_value);
        mismatch_count++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (out_ch.sample_value !== oldest_sample) begin
          $display("%0t: sample_value mismatch, expected %0d, actual %0d",
                   $time, oldest_sample, out_ch.sample_value);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int n;
    addr_t idx;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= OP_WRITE;
    in_ch.x_coord     <= '0;
    in_ch.z_coord     <= '0;
    in_ch.write_index <= '0;
    in_ch.write_value <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.table_side <= '0;

    directed_rows = '{
      '{OP_WRITE,  '0,        '0,        12'd0,    16'sh7FFF, 1'b0, 16'sh0},
      '{OP_WRITE,  '0,        '0,        12'd1,    16'sh8000, 1'b0, 16'sh0},
      '{OP_WRITE,  '0,        '0,        12'd64,   16'sh0000, 1'b0, 16'sh0},
      '{OP_WRITE,  '0,        '0,        12'd65,   16'sh0001, 1'b0, 16'sh0},
      '{OP_SAMPLE, '0,        '0,        12'd0,    16'sh0,    1'b1, 16'sh7FFF},
      '{OP_SAMPLE, CELL,      '0,        12'd0,    16'sh0,    1'b1, 16'sh8000},
      '{OP_SAMPLE, PERIOD,    '0,        12'd0,    16'sh0,    1'b1, 16'sh7FFF},
      '{OP_SAMPLE, NEG_PER,   '0,        12'd0,    16'sh0,    1'b1, 16'sh7FFF},
      '{OP_SAMPLE, '0,        CELL,      12'd0,    16'sh0,    1'b1, 16'sh0000},
      '{OP_SAMPLE, CELL,      CELL,      12'd0,    16'sh0,    1'b1, 16'sh0001},
      // ties: +0.5 rounds up, -0.5 rounds to zero
      '{OP_WRITE,  '0,        '0,        12'd128,  16'sh0000, 1'b0, 16'sh0},
      '{OP_WRITE,  '0,        '0,        12'd129,  16'sh0001, 1'b0, 16'sh0},
      '{OP_SAMPLE, HALF_CELL, 2 * CELL,  12'd0,    16'sh0,    1'b1, 16'sh0001},
      '{OP_WRITE,  '0,        '0,        12'd129,  16'shFFFF, 1'b0, 16'sh0},
      '{OP_SAMPLE, HALF_CELL, 2 * CELL,  12'd0,    16'sh0,    1'b1, 16'sh0000},
      '{OP_WRITE,  '0,        '0,        12'd4095, 16'sh8000, 1'b0, 16'sh0},
      '{OP_SAMPLE, LAST_CELL, LAST_CELL, 12'd0,    16'sh0,    1'b1, 16'sh8000},
      '{OP_SAMPLE, C_MAX,     C_MIN,     12'd0,    16'sh0,    1'b0, 16'sh0},
      '{OP_SAMPLE, C_ONES,    C_MAX,     12'd0,    16'sh0,    1'b0, 16'sh0},
      '{OP_SAMPLE, HALF_CELL, HALF_CELL, 12'd0,    16'sh0,    1'b0, 16'sh0},
      '{OP_SAMPLE, 40'sh00_0012_3456, 40'shAB_CDEF_1234, 12'd0, 16'sh0, 1'b0, 16'sh0}
    };

    phase_sides = '{7'd2, 7'd0, 7'd1, 7'd3, 7'd127, 7'd65, 7'd64, 7'd2, 7'd2, 7'd64};
    phase_sides[7] = cfg_side_t'($urandom_range(4, 63));
    phase_sides[8] = cfg_side_t'($urandom_range(0, 127));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    foreach (directed_rows[r]) begin
      if (directed_rows[r].op == OP_WRITE) begin
        run_write(directed_rows[r].idx, directed_rows[r].val);
      end else begin
        run_sample(directed_rows[r].x, directed_rows[r].z,
                   directed_rows[r].fixed, directed_rows[r].want);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      set_side(phase_sides[p]);
      case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 45;
      endcase
      if (p == N_PHASES - 1) idle_pct = 0;
      n = eff_side(cur_side);
      while (sent_count < (N_ITEMS * (p + 1)) / N_PHASES) begin
        if ($urandom_range(0, 9) < 6) begin
          run_sample(pick_coord(), pick_coord(), 1'b0, '0);
        end else begin
          if ($urandom_range(0, 3) != 0) begin
            idx = addr_t'($urandom_range(0, n * n - 1));
          end else begin
            idx = ADDR_W'($urandom());
          end
          run_write(idx, pick_value());
        end
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
